// File: design/sm83_pkg.sv
// Shared types and constants for the 8-bit CPU ALU with flags.
`timescale 1ns / 1ps

package sm83_pkg;

	// ALU command codes
	typedef enum logic [4:0] {
		CMD_ADD    = 5'd0,
		CMD_ADC    = 5'd1,
		CMD_SUB    = 5'd2,
		CMD_SBC    = 5'd3,
		CMD_AND    = 5'd4,
		CMD_XOR    = 5'd5,
		CMD_OR     = 5'd6,
		CMD_CP     = 5'd7,
		CMD_INC8   = 5'd8,
		CMD_DEC8   = 5'd9,
		CMD_DAA    = 5'd10,
		CMD_CPL    = 5'd11,
		CMD_ADD16  = 5'd12,
		CMD_ADDSPE = 5'd13,
		CMD_INC16  = 5'd14,
		CMD_DEC16  = 5'd15,
		CMD_RLCA   = 5'd16,
		CMD_RLA    = 5'd17,
		CMD_RRCA   = 5'd18,
		CMD_RRA    = 5'd19
	} cmd_t;

	// Flag group: zero, subtract, half-carry, carry
	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} flags_t;

	// Decimal adjust thresholds and corrections
	localparam logic [7:0] DAA_LIMIT  = 8'h9A;
	localparam logic [3:0] NIB_LIMIT  = 4'hA;
	localparam logic [3:0] NIB_MAX    = 4'hF;
	localparam logic [7:0] DAA_ADJ_LO = 8'h06;
	localparam logic [7:0] DAA_ADJ_HI = 8'h60;

endpackage

// File: design/sm83_alu_with_flags.sv
// Top level: input register, ALU datapath, flag register and result register.
//
// Usage:
//   Request channel (req_valid/req_ready) carries command, operand_a and
//   operand_b; one beat is one ALU operation. Response channel
//   (rsp_valid/rsp_ready) returns result_value and the four flags, one beat
//   per request, in order.
//   An accepted request is offered on the response side once it reaches the
//   result register. Throughput: one operation per cycle unless the receiver
//   stalls, set by the single pass through the datapath between the registers.
//   The flag register updates as each operation leaves the input register,
//   so adc, sbc, daa and the rotates through carry see the flags of the
//   operation just before them even back to back.
//   Reset (arst_n low) empties both stages and clears the flag state.
//   When the receiver stalls, the result register holds its beat; the input
//   register takes one more request, then req_ready drops until the
//   response side drains.
`timescale 1ns / 1ps

module sm83_alu_with_flags (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [4:0]  command,
	input  logic [15:0] operand_a,
	input  logic [15:0] operand_b,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [15:0] result_value,
	output logic        zero_flag,
	output logic        subtract_flag,
	output logic        half_carry_flag,
	output logic        carry_flag
);

	logic                valid_s1;
	logic [4:0]          cmd_s1;
	logic [15:0]         a_s1;
	logic [15:0]         b_s1;
	logic                valid_s2;
	logic [15:0]         result_s2;
	sm83_pkg::flags_t    flags_s2;
	sm83_pkg::flags_t    flag_q;
	sm83_pkg::flags_t    flags_next;
	logic [15:0]         result_next;
	logic                s2_free;
	logic                s1_move;

	// Stage handshake
	assign s2_free   = ~valid_s2 | rsp_ready;
	assign s1_move   = valid_s1 & s2_free;
	assign req_ready = ~valid_s1 | s2_free;

	// Input register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	// Input register: payload
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			cmd_s1 <= command;
			a_s1   <= operand_a;
			b_s1   <= operand_b;
		end
	end

	sm83_alu_core u_core (
		.cmd       (cmd_s1),
		.a         (a_s1),
		.b         (b_s1),
		.flags_in  (flag_q),
		.result    (result_next),
		.flags_out (flags_next)
	);

	// Flag state and result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_move) begin
				flag_q <= flags_next;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (s1_move) begin
			result_s2 <= result_next;
			flags_s2  <= flags_next;
		end
	end

	assign rsp_valid       = valid_s2;
	assign result_value    = result_s2;
	assign zero_flag       = flags_s2.z;
	assign subtract_flag   = flags_s2.n;
	assign half_carry_flag = flags_s2.h;
	assign carry_flag      = flags_s2.c;

`ifndef SYNTHESIS
	// Offered flags always match the kept flag state
	a_flags_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (flags_s2 == flag_q))
		else $error("offered flags differ from flag state");

	// Flag state changes only when an operation leaves the input register
	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_move |=> $stable(flag_q))
		else $error("flag state changed without an operation");

	// Word increment and decrement leave the flags alone
	a_inc16_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_move && (cmd_s1 == sm83_pkg::CMD_INC16 || cmd_s1 == sm83_pkg::CMD_DEC16))
		|=> $stable(flag_q))
		else $error("inc16/dec16 altered flags");

	// A waiting operation reaches an empty result register next cycle
	a_s1_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !valid_s2) |=> valid_s2)
		else $error("operation did not advance to result register");
`endif

endmodule

// File: design/sm83_alu_core.sv
// Combinational ALU datapath: result and next flags for one command.
`timescale 1ns / 1ps

module sm83_alu_core (
	input  logic [4:0]            cmd,
	input  logic [15:0]           a,
	input  logic [15:0]           b,
	input  sm83_pkg::flags_t      flags_in,
	output logic [15:0]           result,
	output sm83_pkg::flags_t      flags_out
);

	logic [7:0]  a8;
	logic [7:0]  b8;
	logic        add_cin;
	logic        sub_bin;
	logic [8:0]  sum9;
	logic [4:0]  hsum5;
	logic [8:0]  diff9;
	logic [4:0]  hdiff5;
	logic [7:0]  inc8;
	logic [7:0]  dec8;
	logic [16:0] sum17;
	logic [12:0] hsum13;
	logic [15:0] spe_sum;
	logic        daa_c;
	logic        daa_h;
	logic [7:0]  daa_adj;
	logic [7:0]  daa_res;

	assign a8 = a[7:0];
	assign b8 = b[7:0];

	// Byte add with optional carry in (also feeds the SP offset flags)
	assign add_cin = (cmd == sm83_pkg::CMD_ADC) & flags_in.c;
	assign sum9    = {1'b0, a8} + {1'b0, b8} + {8'b0, add_cin};
	assign hsum5   = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'b0, add_cin};

	// Byte subtract with optional borrow in
	assign sub_bin = (cmd == sm83_pkg::CMD_SBC) & flags_in.c;
	assign diff9   = {1'b0, a8} - {1'b0, b8} - {8'b0, sub_bin};
	assign hdiff5  = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'b0, sub_bin};

	assign inc8 = a8 + 8'd1;
	assign dec8 = a8 - 8'd1;

	// Word add: carry out of bit 11 and bit 15
	assign sum17   = {1'b0, a} + {1'b0, b};
	assign hsum13  = {1'b0, a[11:0]} + {1'b0, b[11:0]};
	assign spe_sum = a + {{8{b8[7]}}, b8};

	// Decimal adjust; carry only ever sets
	assign daa_c   = flags_in.c | (~flags_in.n & (a8 >= sm83_pkg::DAA_LIMIT));
	assign daa_h   = flags_in.h | (~flags_in.n & (a8[3:0] >= sm83_pkg::NIB_LIMIT));
	assign daa_adj = (daa_h ? sm83_pkg::DAA_ADJ_LO : 8'h00)
		| (daa_c ? sm83_pkg::DAA_ADJ_HI : 8'h00);
	assign daa_res = flags_in.n ? (a8 - daa_adj) : (a8 + daa_adj);

	// Select result and flags per command
	always_comb begin
		result    = a;
		flags_out = flags_in;
		case (cmd)
			sm83_pkg::CMD_ADD, sm83_pkg::CMD_ADC: begin
				result    = {8'h00, sum9[7:0]};
				flags_out = '{z: (sum9[7:0] == 8'h00), n: 1'b0, h: hsum5[4], c: sum9[8]};
			end
			sm83_pkg::CMD_SUB, sm83_pkg::CMD_SBC: begin
				result    = {8'h00, diff9[7:0]};
				flags_out = '{z: (diff9[7:0] == 8'h00), n: 1'b1, h: hdiff5[4], c: diff9[8]};
			end
			sm83_pkg::CMD_CP: begin
				result    = a;
				flags_out = '{z: (diff9[7:0] == 8'h00), n: 1'b1, h: hdiff5[4], c: diff9[8]};
			end
			sm83_pkg::CMD_AND: begin
				result    = {8'h00, a8 & b8};
				flags_out = '{z: ((a8 & b8) == 8'h00), n: 1'b0, h: 1'b1, c: 1'b0};
			end
			sm83_pkg::CMD_XOR: begin
				result    = {8'h00, a8 ^ b8};
				flags_out = '{z: ((a8 ^ b8) == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			sm83_pkg::CMD_OR: begin
				result    = {8'h00, a8 | b8};
				flags_out = '{z: ((a8 | b8) == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			sm83_pkg::CMD_INC8: begin
				result    = {8'h00, inc8};
				flags_out = '{z: (inc8 == 8'h00), n: 1'b0,
					h: (a8[3:0] == sm83_pkg::NIB_MAX), c: flags_in.c};
			end
			sm83_pkg::CMD_DEC8: begin
				result    = {8'h00, dec8};
				flags_out = '{z: (dec8 == 8'h00), n: 1'b1,
					h: (a8[3:0] == 4'h0), c: flags_in.c};
			end
			sm83_pkg::CMD_DAA: begin
				result    = {8'h00, daa_res};
				flags_out = '{z: (daa_res == 8'h00), n: flags_in.n, h: 1'b0, c: daa_c};
			end
			sm83_pkg::CMD_CPL: begin
				result    = {8'h00, ~a8};
				flags_out = '{z: flags_in.z, n: 1'b1, h: 1'b1, c: flags_in.c};
			end
			sm83_pkg::CMD_ADD16: begin
				result    = sum17[15:0];
				flags_out = '{z: flags_in.z, n: 1'b0, h: hsum13[12], c: sum17[16]};
			end
			sm83_pkg::CMD_ADDSPE: begin
				result    = spe_sum;
				flags_out = '{z: 1'b0, n: 1'b0, h: hsum5[4], c: sum9[8]};
			end
			sm83_pkg::CMD_INC16: begin
				result = a + 16'd1;
			end
			sm83_pkg::CMD_DEC16: begin
				result = a - 16'd1;
			end
			sm83_pkg::CMD_RLCA, sm83_pkg::CMD_RLA: begin
				result    = {8'h00, a8[6:0],
					((cmd == sm83_pkg::CMD_RLCA) ? a8[7] : flags_in.c)};
				flags_out = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a8[7]};
			end
			sm83_pkg::CMD_RRCA, sm83_pkg::CMD_RRA: begin
				result    = {8'h00, ((cmd == sm83_pkg::CMD_RRCA) ? a8[0] : flags_in.c),
					a8[7:1]};
				flags_out = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a8[0]};
			end
			default: begin
				result    = a;
				flags_out = flags_in;
			end
		endcase
	end

endmodule

// File: tb/sm83_alu_flag_checker.sv
// Checker for the ALU: watches both channels, predicts each result and compares it.
`timescale 1ns / 1ps

module sm83_alu_flag_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  logic [4:0]  command,
	input  logic [15:0] operand_a,
	input  logic [15:0] operand_b,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  logic [15:0] result_value,
	input  logic        zero_flag,
	input  logic        subtract_flag,
	input  logic        half_carry_flag,
	input  logic        carry_flag,
	output int          fail_count,
	output int          results_checked,
	output int          results_pending
);

	localparam int MAX_PRINTED = 40;

	typedef struct packed {
		logic [4:0]       cmd;
		logic [15:0]      value;
		sm83_pkg::flags_t flags;
	} alu_result_t;

	alu_result_t      alu_results_due[$];
	alu_result_t      oldest_due;
	alu_result_t      next_due;
	sm83_pkg::flags_t flag_state;
	sm83_pkg::flags_t seen_flags;
	int               error_count = 0;
	int               checked_count = 0;

	assign fail_count      = error_count;
	assign results_checked = checked_count;

	// Compute the value and the updated flags of one ALU operation
	function automatic alu_result_t compute_alu_result(input logic [4:0] cmd,
			input logic [15:0] a16, input logic [15:0] b16, input sm83_pkg::flags_t f_in);
		logic [7:0]  a;
		logic [7:0]  b;
		logic [7:0]  r8;
		logic [7:0]  adj;
		logic [8:0]  s9;
		logic [4:0]  s5;
		logic [12:0] s13;
		logic [16:0] s17;
		logic        cin;
		alu_result_t res;
		a = a16[7:0];
		b = b16[7:0];
		res.cmd = cmd;
		res.value = a16;
		res.flags = f_in;
		case (cmd)
			sm83_pkg::CMD_ADD, sm83_pkg::CMD_ADC: begin
				cin = (cmd == sm83_pkg::CMD_ADC) ? f_in.c : 1'b0;
				s9 = {1'b0, a} + {1'b0, b} + {8'h00, cin};
				s5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cin};
				res.value = {8'h00, s9[7:0]};
				res.flags = {s9[7:0] == 8'h00, 1'b0, s5[4], s9[8]};
			end
			sm83_pkg::CMD_SUB, sm83_pkg::CMD_SBC, sm83_pkg::CMD_CP: begin
				cin = (cmd == sm83_pkg::CMD_SBC) ? f_in.c : 1'b0;
				s9 = {1'b0, a} - {1'b0, b} - {8'h00, cin};
				s5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, cin};
				res.flags = {s9[7:0] == 8'h00, 1'b1, s5[4], s9[8]};
				// compare keeps the whole destination word
				res.value = (cmd == sm83_pkg::CMD_CP) ? a16 : {8'h00, s9[7:0]};
			end
			sm83_pkg::CMD_AND: begin
				r8 = a & b;
				res.value = {8'h00, r8};
				res.flags = {r8 == 8'h00, 1'b0, 1'b1, 1'b0};
			end
			sm83_pkg::CMD_XOR: begin
				r8 = a ^ b;
				res.value = {8'h00, r8};
				res.flags = {r8 == 8'h00, 1'b0, 1'b0, 1'b0};
			end
			sm83_pkg::CMD_OR: begin
				r8 = a | b;
				res.value = {8'h00, r8};
				res.flags = {r8 == 8'h00, 1'b0, 1'b0, 1'b0};
			end
			sm83_pkg::CMD_INC8: begin
				r8 = a + 8'h01;
				res.value = {8'h00, r8};
				res.flags = {r8 == 8'h00, 1'b0, a[3:0] == sm83_pkg::NIB_MAX, f_in.c};
			end
			sm83_pkg::CMD_DEC8: begin
				r8 = a - 8'h01;
				res.value = {8'h00, r8};
				res.flags = {r8 == 8'h00, 1'b1, a[3:0] == 4'h0, f_in.c};
			end
			sm83_pkg::CMD_DAA: begin
				// after an add, raise the corrections the digits call for
				if (!f_in.n) begin
					if (a >= sm83_pkg::DAA_LIMIT)
						res.flags.c = 1'b1;
					if (a[3:0] >= sm83_pkg::NIB_LIMIT)
						res.flags.h = 1'b1;
				end
				adj = (res.flags.h ? sm83_pkg::DAA_ADJ_LO : 8'h00)
					| (res.flags.c ? sm83_pkg::DAA_ADJ_HI : 8'h00);
				r8 = f_in.n ? a - adj : a + adj;
				res.value = {8'h00, r8};
				res.flags = {r8 == 8'h00, f_in.n, 1'b0, res.flags.c};
			end
			sm83_pkg::CMD_CPL: begin
				res.value = {8'h00, ~a};
				res.flags = {f_in.z, 1'b1, 1'b1, f_in.c};
			end
			sm83_pkg::CMD_ADD16: begin
				s17 = {1'b0, a16} + {1'b0, b16};
				s13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
				res.value = s17[15:0];
				res.flags = {f_in.z, 1'b0, s13[12], s17[16]};
			end
			sm83_pkg::CMD_ADDSPE: begin
				// value uses the signed offset, flags the unsigned low bytes
				s9 = {1'b0, a} + {1'b0, b};
				s5 = {1'b0, a[3:0]} + {1'b0, b[3:0]};
				res.value = a16 + {{8{b[7]}}, b};
				res.flags = {1'b0, 1'b0, s5[4], s9[8]};
			end
			sm83_pkg::CMD_INC16: res.value = a16 + 16'h0001;
			sm83_pkg::CMD_DEC16: res.value = a16 - 16'h0001;
			sm83_pkg::CMD_RLCA, sm83_pkg::CMD_RLA: begin
				cin = (cmd == sm83_pkg::CMD_RLCA) ? a[7] : f_in.c;
				res.value = {8'h00, a[6:0], cin};
				res.flags = {1'b0, 1'b0, 1'b0, a[7]};
			end
			sm83_pkg::CMD_RRCA, sm83_pkg::CMD_RRA: begin
				cin = (cmd == sm83_pkg::CMD_RRCA) ? a[0] : f_in.c;
				res.value = {8'h00, cin, a[7:1]};
				res.flags = {1'b0, 1'b0, 1'b0, a[0]};
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [4:0] cmd,
			input logic [15:0] got, input logic [15:0] want);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("ERROR at %0t: cmd %0d %s: got 0x%04h, expected 0x%04h",
				$time, cmd, what, got, want);
	endtask

	// Check each response beat against the oldest prediction, then queue new requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_state = '0;
			alu_results_due.delete();
			results_pending <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				checked_count++;
				seen_flags = {zero_flag, subtract_flag, half_carry_flag, carry_flag};
				if (alu_results_due.size() == 0) begin
					report_mismatch("result with nothing outstanding", 5'd0,
						result_value, 16'h0000);
				end else begin
					oldest_due = alu_results_due.pop_front();
					if (result_value !== oldest_due.value)
						report_mismatch("result_value", oldest_due.cmd,
							result_value, oldest_due.value);
					if (seen_flags.z !== oldest_due.flags.z)
						report_mismatch("zero_flag", oldest_due.cmd,
							{15'd0, seen_flags.z}, {15'd0, oldest_due.flags.z});
					if (seen_flags.n !== oldest_due.flags.n)
						report_mismatch("subtract_flag", oldest_due.cmd,
							{15'd0, seen_flags.n}, {15'd0, oldest_due.flags.n});
					if (seen_flags.h !== oldest_due.flags.h)
						report_mismatch("half_carry_flag", oldest_due.cmd,
							{15'd0, seen_flags.h}, {15'd0, oldest_due.flags.h});
					if (seen_flags.c !== oldest_due.flags.c)
						report_mismatch("carry_flag", oldest_due.cmd,
							{15'd0, seen_flags.c}, {15'd0, oldest_due.flags.c});
				end
			end
			if (req_valid && req_ready) begin
				next_due = compute_alu_result(command, operand_a, operand_b, flag_state);
				flag_state = next_due.flags;
				alu_results_due.push_back(next_due);
			end
			results_pending <= alu_results_due.size();
		end
	end

endmodule

// File: tb/sm83_alu_with_flags_tb.sv
// Testbench top: drives ALU operations, paces the result side and gives the verdict.
`timescale 1ns / 1ps

module sm83_alu_with_flags_tb;

	localparam int         CYCLE_LIMIT      = 200000;
	localparam int         RANDOM_OPS       = 320;
	localparam int         BURST_OPS        = 24;
	localparam int         LONG_HOLD_CYCLES = 40;
	localparam int         SETTLE_CYCLES    = 8;
	localparam logic [4:0] CMD_UNUSED_LO    = 5'd20;
	localparam logic [4:0] CMD_UNUSED_HI    = 5'd31;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	logic [4:0]  command;
	logic [15:0] operand_a;
	logic [15:0] operand_b;
	logic        rsp_valid;
	logic        rsp_ready;
	logic [15:0] result_value;
	logic        zero_flag;
	logic        subtract_flag;
	logic        half_carry_flag;
	logic        carry_flag;

	int          fail_count;
	int          results_checked;
	int          results_pending;
	int          cycle_count = 0;
	int          ops_sent = 0;
	bit [31:0]   codes_seen = '0;
	int          send_gap_max;
	int          recv_gap_max;
	bit          hold_request;

	sm83_alu_with_flags dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.command         (command),
		.operand_a       (operand_a),
		.operand_b       (operand_b),
		.rsp_valid       (rsp_valid),
		.rsp_ready       (rsp_ready),
		.result_value    (result_value),
		.zero_flag       (zero_flag),
		.subtract_flag   (subtract_flag),
		.half_carry_flag (half_carry_flag),
		.carry_flag      (carry_flag)
	);

	sm83_alu_flag_checker result_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.command         (command),
		.operand_a       (operand_a),
		.operand_b       (operand_b),
		.rsp_valid       (rsp_valid),
		.rsp_ready       (rsp_ready),
		.result_value    (result_value),
		.zero_flag       (zero_flag),
		.subtract_flag   (subtract_flag),
		.half_carry_flag (half_carry_flag),
		.carry_flag      (carry_flag),
		.fail_count      (fail_count),
		.results_checked (results_checked),
		.results_pending (results_pending)
	);

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Verification failed");
			$finish;
		end
	end

	// Result side: random idle before each beat, plus one long hold on request
	initial begin
		int idle;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end
			idle = $urandom_range(0, recv_gap_max);
			if (idle > 0) begin
				rsp_ready <= 1'b0;
				repeat (idle) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid)
				@(posedge clk);
		end
	end

	// Offer one request beat after a random idle and hold it until taken
	task automatic send_op(input logic [4:0] cmd, input logic [15:0] a, input logic [15:0] b);
		int idle;
		idle = $urandom_range(0, send_gap_max);
		if (idle > 0) begin
			req_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		req_valid <= 1'b1;
		command   <= cmd;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		ops_sent++;
		codes_seen[cmd] = 1'b1;
	endtask

	// Stop offering and wait until every outstanding result has come back
	task automatic drain_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0)
			@(posedge clk);
	endtask

	// Favor boundary words, otherwise fully random
	function automatic logic [15:0] pick_operand();
		logic [15:0] w;
		w = $urandom();
		case ($urandom_range(0, 7))
			0: w = 16'h0000;
			1: w = 16'hFFFF;
			2: w = {w[15:8], 8'hFF};
			3: w = {w[15:8], 8'h00};
			4: w = {w[15:8], w[7:4], 4'hF};
			5: w = {8'h00, w[7:0]};
			default: ;
		endcase
		return w;
	endfunction

	// One random step: a decimal add or subtract with its adjust, an unused code,
	// or any command with boundary-heavy operands
	task automatic send_random_op();
		logic [7:0]  x;
		logic [7:0]  y;
		logic [15:0] hi_bits;
		int          pick;
		hi_bits = $urandom();
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			x = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
			y = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
			if (pick < 6) begin
				send_op(sm83_pkg::CMD_ADD, {hi_bits[15:8], x}, {hi_bits[7:0], y});
				send_op(sm83_pkg::CMD_DAA, {hi_bits[7:0], 8'(x + y)}, pick_operand());
			end else begin
				send_op(sm83_pkg::CMD_SUB, {hi_bits[15:8], x}, {hi_bits[7:0], y});
				send_op(sm83_pkg::CMD_DAA, {hi_bits[7:0], 8'(x - y)}, pick_operand());
			end
		end else if (pick < 16) begin
			send_op(5'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)),
				pick_operand(), pick_operand());
		end else begin
			send_op(5'($urandom_range(sm83_pkg::CMD_ADD, sm83_pkg::CMD_RRA)),
				pick_operand(), pick_operand());
		end
	endtask

	initial begin
		int phase;
		int n;
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		command      = sm83_pkg::CMD_ADD;
		operand_a    = '0;
		operand_b    = '0;
		hold_request = 1'b0;
		send_gap_max = 4;
		recv_gap_max = 4;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: carry chain through adc and sbc
		send_op(sm83_pkg::CMD_ADD, 16'hABFF, 16'h5401);
		send_op(sm83_pkg::CMD_ADC, 16'h000F, 16'hFF00);
		send_op(sm83_pkg::CMD_SUB, 16'h0000, 16'h0001);
		send_op(sm83_pkg::CMD_SBC, 16'h0010, 16'h000F);
		// logic ops: zero results from and and xor, a nonzero one from or
		send_op(sm83_pkg::CMD_AND, 16'h00F0, 16'h000F);
		send_op(sm83_pkg::CMD_XOR, 16'h12FF, 16'h34FF);
		send_op(sm83_pkg::CMD_OR,  16'h0000, 16'h0080);
		// compare returns the full destination word
		send_op(sm83_pkg::CMD_CP,  16'hFFFF, 16'h00FF);
		send_op(sm83_pkg::CMD_INC8, 16'h00FF, 16'h0000);
		send_op(sm83_pkg::CMD_DEC8, 16'h0010, 16'h0000);
		// decimal adjust after add, after subtract, and past the upper limit
		send_op(sm83_pkg::CMD_ADD, 16'h0015, 16'h0027);
		send_op(sm83_pkg::CMD_DAA, 16'h003C, 16'h0000);
		send_op(sm83_pkg::CMD_SUB, 16'h0042, 16'h0015);
		send_op(sm83_pkg::CMD_DAA, 16'h002D, 16'h0000);
		send_op(sm83_pkg::CMD_OR,  16'h0000, 16'h0000);
		send_op(sm83_pkg::CMD_DAA, 16'h009A, 16'h0000);
		send_op(sm83_pkg::CMD_CPL, 16'hFF5A, 16'h0000);
		// 16-bit adds: bit-11 carry, bit-15 carry, negative offset
		send_op(sm83_pkg::CMD_ADD16, 16'h0FFF, 16'h0001);
		send_op(sm83_pkg::CMD_ADD16, 16'hFFFF, 16'h0001);
		send_op(sm83_pkg::CMD_ADDSPE, 16'h00FF, 16'hFF81);
		send_op(sm83_pkg::CMD_INC16, 16'hFFFF, 16'h0000);
		send_op(sm83_pkg::CMD_DEC16, 16'h0000, 16'h0000);
		// rotates, the through-carry ones after a carry out
		send_op(sm83_pkg::CMD_RLCA, 16'h0080, 16'h0000);
		send_op(sm83_pkg::CMD_RLA,  16'h0001, 16'h0000);
		send_op(sm83_pkg::CMD_RRCA, 16'h0001, 16'h0000);
		send_op(sm83_pkg::CMD_RRA,  16'h0080, 16'h0000);
		// unused codes leave everything alone
		send_op(CMD_UNUSED_LO, 16'hBEEF, 16'h1234);
		send_op(CMD_UNUSED_HI, 16'h8001, 16'hFFFF);
		drain_results();

		// Random: both sides idle, sender streams, receiver streams, neither idles
		for (phase = 0; phase < 4; phase++) begin
			send_gap_max = (phase == 0 || phase == 2) ? 4 : 0;
			recv_gap_max = (phase == 0 || phase == 1) ? 4 : 0;
			for (n = 0; n < RANDOM_OPS / 4; n++)
				send_random_op();
			if (phase == 0) begin
				// hold the result side while requests keep coming, so input stalls
				hold_request = 1'b1;
				send_gap_max = 0;
				for (n = 0; n < BURST_OPS; n++)
					send_random_op();
			end else if (phase == 1) begin
				drain_results();
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d operations covering %0d command codes; %0d results checked,",
			ops_sent, $countones(codes_seen), results_checked);
		$display("with random idles on both sides and a %0d-cycle result hold.",
			LONG_HOLD_CYCLES);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
